FILE: hdl/stereo_frame_selector_macros.svh
// Assertion helpers for the stereo frame selector checker.
// Each expects clk and rst_n in scope.
`ifndef STEREO_FRAME_SELECTOR_MACROS_SVH
`define STEREO_FRAME_SELECTOR_MACROS_SVH

// same-cycle implication
`define SSEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ssel_pkg.sv
package ssel_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int MAX_SKEW_US_DEF  = 2000;

    localparam int TAG_W    = 16;
    localparam int STAMP_W  = 48;
    localparam int SHARP_W  = 32;
    localparam int BRIGHT_W = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SHARPNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LAT    = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SELECTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DESYNC     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DECIMATED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RATE       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUALITY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HELD       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FLUSH_RATE = 3'd6;

    // register reset values
    localparam logic               RST_SELECT_MODE = 1'b0;
    localparam logic [7:0]         RST_DECIMATION  = 8'd1;
    localparam logic [23:0]        RST_MIN_INTERVAL = 24'd0;
    localparam logic [31:0]        RST_MIN_SHARP   = 32'd0;
    localparam logic signed [16:0] RST_MIN_BRIGHT  = -17'sd1;
    localparam logic [16:0]        RST_MAX_BRIGHT  = 17'd65536;
    localparam logic [3:0]         RST_WINDOW_SIZE = 4'd3;
    localparam logic [23:0]        RST_WINDOW_LAT  = 24'd150000;

    // 255.0 in Q8.8; an upper bound above it turns the gate off
    localparam logic [16:0] BRIGHT_GATE_OFF = 17'd65280;

    typedef struct packed {
        logic load;
        logic check;
        logic append;
        logic trim;
        logic age;
        logic scan_step;
        logic pick;
        logic emit;
    } ssel_cmd_t;

    typedef struct packed {
        logic check_done;
        logic flush;
        logic scan_end;
    } ssel_stat_t;

endpackage

FILE: hdl/ssel_ctrl.sv
module ssel_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ssel_pkg::ssel_stat_t stat,
    output ssel_pkg::ssel_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_APPEND = 8'b0000_0100,
        S_TRIM   = 8'b0000_1000,
        S_AGE    = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_PICK   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.check_done ? S_DONE : S_APPEND;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                cmd.trim   = 1'b1;
                state_next = S_AGE;
            end
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = stat.flush ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/ssel_dp.sv
module ssel_dp
#(
    parameter int WINDOW_DEPTH = ssel_pkg::WINDOW_DEPTH_DEF,
    parameter int MAX_SKEW_US  = ssel_pkg::MAX_SKEW_US_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssel_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ssel_pkg::TAG_W-1:0]          frame_tag,
    input  logic [ssel_pkg::STAMP_W-1:0]        left_stamp_us,
    input  logic [ssel_pkg::STAMP_W-1:0]        right_stamp_us,
    input  logic [ssel_pkg::SHARP_W-1:0]        sharpness,
    input  logic [ssel_pkg::BRIGHT_W-1:0]       brightness,
    input  ssel_pkg::ssel_cmd_t                 cmd,
    output ssel_pkg::ssel_stat_t                stat,
    output logic [ssel_pkg::STATUS_W-1:0]       status,
    output logic [ssel_pkg::TAG_W-1:0]          selected_tag,
    output logic [ssel_pkg::STAMP_W-1:0]        selected_stamp_us
);

    localparam int TAG_W   = ssel_pkg::TAG_W;
    localparam int STAMP_W = ssel_pkg::STAMP_W;
    localparam int SHARP_W = ssel_pkg::SHARP_W;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SZ_W    = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SZ_W-1:0]  DEPTH_SZ  = SZ_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [STAMP_W-1:0] SKEW_LIM = STAMP_W'(MAX_SKEW_US);

    // configuration
    logic               mode_reg;
    logic [7:0]         dec_reg;
    logic [23:0]        min_int_reg;
    logic [31:0]        min_sharp_reg;
    logic signed [16:0] min_bright_reg;
    logic [16:0]        max_bright_reg;
    logic [3:0]         wsize_reg;
    logic [23:0]        wlat_reg;

    // beat under work
    logic [TAG_W-1:0]            tag_reg;
    logic [STAMP_W-1:0]          ls_reg;
    logic [STAMP_W-1:0]          rs_reg;
    logic [SHARP_W-1:0]          sharp_reg;
    logic [ssel_pkg::BRIGHT_W-1:0] bright_reg;

    // selector state
    logic [7:0]         phase_reg;
    logic [STAMP_W-1:0] last_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TAG_W-1:0]   win_tag   [WINDOW_DEPTH];
    logic [STAMP_W-1:0] win_stamp [WINDOW_DEPTH];
    logic [SHARP_W-1:0] win_score [WINDOW_DEPTH];

    // flush scan
    logic [CNT_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   best_reg;
    logic [SHARP_W-1:0] best_score_reg;

    // result and output stage
    logic [ssel_pkg::STATUS_W-1:0] res_status_reg;
    logic [TAG_W-1:0]              res_tag_reg;
    logic [STAMP_W-1:0]            res_stamp_reg;
    logic [ssel_pkg::STATUS_W-1:0] out_status_reg;
    logic [TAG_W-1:0]              out_tag_reg;
    logic [STAMP_W-1:0]            out_stamp_reg;

    logic [STAMP_W-1:0] skew;
    logic               desync;
    logic [7:0]         dec_eff;
    logic [8:0]         phase_inc;
    logic [7:0]         phase_next;
    logic               decimated;
    logic               soon_ls;
    logic               gate_fail;
    logic [SZ_W-1:0]    size_eff;
    logic [SZ_W-1:0]    count_ext;
    logic               full;
    logic               over;
    logic               age_hit;
    logic               shift;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   scan_idx;
    logic [SHARP_W-1:0] scan_score;
    logic [TAG_W-1:0]   sel_tag;
    logic [STAMP_W-1:0] sel_stamp;
    logic               soon_sel;

    function automatic logic too_soon(input logic [STAMP_W-1:0] s,
                                      input logic [STAMP_W-1:0] last,
                                      input logic [23:0] lim);
        logic [STAMP_W-1:0] gap;
        gap = s - last;
        return (lim != '0) && (last != '0) && (s != '0) && (s >= last) &&
               (gap < STAMP_W'(lim));
    endfunction

    assign skew      = (ls_reg >= rs_reg) ? (ls_reg - rs_reg) : (rs_reg - ls_reg);
    assign desync    = (ls_reg != '0) && (rs_reg != '0) && (skew > SKEW_LIM);
    assign dec_eff   = (dec_reg == '0) ? 8'd1 : dec_reg;
    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign phase_next = (phase_inc >= {1'b0, dec_eff}) ? 8'd0 : phase_inc[7:0];
    assign decimated = (dec_eff > 8'd1) && (phase_reg != '0);
    assign soon_ls   = too_soon(ls_reg, last_reg, min_int_reg);

    assign gate_fail = ((min_sharp_reg != '0) && (sharp_reg < min_sharp_reg)) ||
                       (!min_bright_reg[16] && (bright_reg < min_bright_reg[15:0])) ||
                       ((max_bright_reg <= ssel_pkg::BRIGHT_GATE_OFF) &&
                        ({1'b0, bright_reg} > max_bright_reg));

    assign size_eff  = (wsize_reg == '0) ? SZ_W'(1) :
                       ((SZ_W'(wsize_reg) > DEPTH_SZ) ? DEPTH_SZ : SZ_W'(wsize_reg));
    assign count_ext = SZ_W'(count_reg);
    assign full      = (count_reg >= DEPTH_CNT);
    assign over      = (count_ext > size_eff);
    assign age_hit   = (wlat_reg != '0) && (ls_reg != '0) && (win_stamp[0] != '0) &&
                       (ls_reg >= win_stamp[0]) &&
                       ((ls_reg - win_stamp[0]) >= STAMP_W'(wlat_reg));

    assign shift  = (cmd.append && full) || (cmd.trim && over);
    assign wr_en  = cmd.append;
    assign wr_idx = full ? LAST_IDX : count_reg[IDX_W-1:0];

    assign scan_idx   = idx_reg[IDX_W-1:0];
    assign scan_score = win_score[scan_idx];
    assign sel_tag    = win_tag[best_reg];
    assign sel_stamp  = win_stamp[best_reg];
    assign soon_sel   = too_soon(sel_stamp, last_reg, min_int_reg);

    assign stat.check_done = desync || !mode_reg || gate_fail;
    assign stat.flush      = (count_ext >= size_eff) || age_hit;
    assign stat.scan_end   = (idx_reg >= count_reg);

    assign status            = out_status_reg;
    assign selected_tag      = out_tag_reg;
    assign selected_stamp_us = out_stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ssel_pkg::RST_SELECT_MODE;
            dec_reg        <= ssel_pkg::RST_DECIMATION;
            min_int_reg    <= ssel_pkg::RST_MIN_INTERVAL;
            min_sharp_reg  <= ssel_pkg::RST_MIN_SHARP;
            min_bright_reg <= ssel_pkg::RST_MIN_BRIGHT;
            max_bright_reg <= ssel_pkg::RST_MAX_BRIGHT;
            wsize_reg      <= ssel_pkg::RST_WINDOW_SIZE;
            wlat_reg       <= ssel_pkg::RST_WINDOW_LAT;
            phase_reg      <= '0;
            last_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ssel_pkg::REG_SELECT_MODE:   mode_reg       <= cfg_data[0];
                    ssel_pkg::REG_DECIMATION:    dec_reg        <= cfg_data[7:0];
                    ssel_pkg::REG_MIN_INTERVAL:  min_int_reg    <= cfg_data[23:0];
                    ssel_pkg::REG_MIN_SHARPNESS: min_sharp_reg  <= cfg_data[31:0];
                    ssel_pkg::REG_MIN_BRIGHT:    min_bright_reg <= cfg_data[16:0];
                    ssel_pkg::REG_MAX_BRIGHT:    max_bright_reg <= cfg_data[16:0];
                    ssel_pkg::REG_WINDOW_SIZE:   wsize_reg      <= cfg_data[3:0];
                    ssel_pkg::REG_WINDOW_LAT:    wlat_reg       <= cfg_data[23:0];
                    default:                     mode_reg       <= mode_reg;
                endcase
            end

            priority if (cfg_we && (cfg_index == ssel_pkg::REG_DECIMATION))
            begin
                phase_reg <= '0;
            end
            else if (cmd.check && !desync)
            begin
                phase_reg <= phase_next;
            end

            priority if (cmd.check && !desync && !mode_reg && !decimated && !soon_ls &&
                         (min_int_reg != '0) && (ls_reg != '0))
            begin
                last_reg <= ls_reg;
            end
            else if (cmd.pick && !soon_sel && (sel_stamp != '0))
            begin
                last_reg <= sel_stamp;
            end

            priority if (cmd.append && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.trim && over)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.pick)
            begin
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg    <= frame_tag;
            ls_reg     <= left_stamp_us;
            rs_reg     <= right_stamp_us;
            sharp_reg  <= sharpness;
            bright_reg <= brightness;
        end

        // window entries shift toward the oldest slot; the new entry lands last
        for (int k = 0; k < WINDOW_DEPTH - 1; k++)
        begin
            if (shift)
            begin
                win_tag[k]   <= win_tag[k + 1];
                win_stamp[k] <= win_stamp[k + 1];
                win_score[k] <= win_score[k + 1];
            end
        end
        if (wr_en)
        begin
            win_tag[wr_idx]   <= tag_reg;
            win_stamp[wr_idx] <= ls_reg;
            win_score[wr_idx] <= sharp_reg;
        end

        if (cmd.age)
        begin
            idx_reg        <= CNT_W'(1);
            best_reg       <= '0;
            best_score_reg <= win_score[0];
        end
        else if (cmd.scan_step && !stat.scan_end)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (scan_score > best_score_reg)
            begin
                best_reg       <= scan_idx;
                best_score_reg <= scan_score;
            end
        end

        if (cmd.check)
        begin
            res_tag_reg   <= '0;
            res_stamp_reg <= '0;
            priority if (desync)
            begin
                res_status_reg <= ssel_pkg::ST_DESYNC;
            end
            else if (mode_reg)
            begin
                res_status_reg <= ssel_pkg::ST_QUALITY;
            end
            else if (decimated)
            begin
                res_status_reg <= ssel_pkg::ST_DECIMATED;
            end
            else if (soon_ls)
            begin
                res_status_reg <= ssel_pkg::ST_RATE;
            end
            else
            begin
                res_status_reg <= ssel_pkg::ST_SELECTED;
                res_tag_reg    <= tag_reg;
                res_stamp_reg  <= ls_reg;
            end
        end
        else if (cmd.age)
        begin
            res_status_reg <= ssel_pkg::ST_HELD;
            res_tag_reg    <= '0;
            res_stamp_reg  <= '0;
        end
        else if (cmd.pick)
        begin
            if (soon_sel)
            begin
                res_status_reg <= ssel_pkg::ST_FLUSH_RATE;
                res_tag_reg    <= '0;
                res_stamp_reg  <= '0;
            end
            else
            begin
                res_status_reg <= ssel_pkg::ST_SELECTED;
                res_tag_reg    <= sel_tag;
                res_stamp_reg  <= sel_stamp;
            end
        end

        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_tag_reg    <= res_tag_reg;
            out_stamp_reg  <= res_stamp_reg;
        end
    end

endmodule

FILE: hdl/stereo_frame_selector.sv
// Flow: an accepted beat runs CHECK, DONE for stride mode, desync and quality
//   rejects; CHECK, APPEND, TRIM, AGE, DONE for a held candidate; a flush adds
//   SCAN and PICK before DONE, which waits while the prior output beat stalls.
// One beat at a time (window scan reads one candidate score per cycle); the
//   output register frees the input side early.
// Reset (rst_n, async, active low) clears the registers to their defaults,
//   the stride phase, the last selected stamp and the window count.
module stereo_frame_selector
#(
    parameter int WINDOW_DEPTH = ssel_pkg::WINDOW_DEPTH_DEF,
    parameter int MAX_SKEW_US  = ssel_pkg::MAX_SKEW_US_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ssel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssel_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ssel_pkg::TAG_W-1:0]         frame_tag,
    input  logic [ssel_pkg::STAMP_W-1:0]       left_stamp_us,
    input  logic [ssel_pkg::STAMP_W-1:0]       right_stamp_us,
    input  logic [ssel_pkg::SHARP_W-1:0]       sharpness,
    input  logic [ssel_pkg::BRIGHT_W-1:0]      brightness,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ssel_pkg::STATUS_W-1:0]      status,
    output logic [ssel_pkg::TAG_W-1:0]         selected_tag,
    output logic [ssel_pkg::STAMP_W-1:0]       selected_stamp_us
);

    ssel_pkg::ssel_cmd_t  cmd;
    ssel_pkg::ssel_stat_t stat;

    ssel_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssel_dp
    #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_SKEW_US  (MAX_SKEW_US)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .frame_tag         (frame_tag),
        .left_stamp_us     (left_stamp_us),
        .right_stamp_us    (right_stamp_us),
        .sharpness         (sharpness),
        .brightness        (brightness),
        .cmd               (cmd),
        .stat              (stat),
        .status            (status),
        .selected_tag      (selected_tag),
        .selected_stamp_us (selected_stamp_us)
    );

endmodule

FILE: hdl/ssel_chk.sv
`include "stereo_frame_selector_macros.svh"

module ssel_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ssel_pkg::STATUS_W-1:0] status,
    input logic [ssel_pkg::TAG_W-1:0]    selected_tag,
    input logic [ssel_pkg::STAMP_W-1:0]  selected_stamp_us
);

    // non-selected results carry no frame
    `SSEL_ASSERT_NOW(a_zero_payload, out_valid && (status != ssel_pkg::ST_SELECTED), (selected_tag == '0) && (selected_stamp_us == '0), "non-selected beat carries a frame")

    `SSEL_ASSERT_NOW(a_status_range, out_valid, status <= ssel_pkg::ST_FLUSH_RATE, "status code out of range")

    // one beat at a time: the input side closes right after an accept
    `SSEL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input accepted while busy")

    `SSEL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(selected_tag) && $stable(selected_stamp_us), "stalled output beat changed")

endmodule

bind stereo_frame_selector ssel_chk u_ssel_chk
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .selected_tag      (selected_tag),
    .selected_stamp_us (selected_stamp_us)
);

FILE: bench/stereo_frame_selector_check.sv
module stereo_frame_selector_check
    import ssel_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int MAX_SKEW_US  = MAX_SKEW_US_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [TAG_W-1:0]      frame_tag,
    input  logic [STAMP_W-1:0]    left_stamp_us,
    input  logic [STAMP_W-1:0]    right_stamp_us,
    input  logic [SHARP_W-1:0]    sharpness,
    input  logic [BRIGHT_W-1:0]   brightness,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [STATUS_W-1:0]   status,
    input  logic [TAG_W-1:0]      selected_tag,
    input  logic [STAMP_W-1:0]    selected_stamp_us,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [STAMP_W-1:0]  stamp;
    } verdict_t;

    verdict_t verdict_q[$];

    logic        quality_mode;
    logic [7:0]  keep_one_in;
    logic [23:0] min_gap_us;
    logic [31:0] sharp_floor;
    logic [16:0] bright_floor;
    logic [16:0] bright_ceil;
    logic [3:0]  window_goal;
    logic [23:0] age_limit_us;

    int                stride_pos;
    logic [STAMP_W-1:0] last_pick_us;
    logic [TAG_W-1:0]   cand_tag[WINDOW_DEPTH];
    logic [STAMP_W-1:0] cand_stamp[WINDOW_DEPTH];
    logic [SHARP_W-1:0] cand_score[WINDOW_DEPTH];
    int                 cand_count;

    function automatic bit too_soon(input logic [STAMP_W-1:0] stamp);
        if (min_gap_us == 0 || last_pick_us == 0 || stamp == 0)
            return 1'b0;
        if (stamp < last_pick_us)
            return 1'b0;
        return (stamp - last_pick_us) < {24'd0, min_gap_us};
    endfunction

    function automatic void shift_out_oldest();
        if (cand_count == 0)
            return;
        for (int i = 1; i < cand_count; i++)
        begin
            cand_tag[i-1]   = cand_tag[i];
            cand_stamp[i-1] = cand_stamp[i];
            cand_score[i-1] = cand_score[i];
        end
        cand_count--;
    endfunction

    function automatic verdict_t judge_frame(
        input logic [TAG_W-1:0]    tag,
        input logic [STAMP_W-1:0]  ls,
        input logic [STAMP_W-1:0]  rs,
        input logic [SHARP_W-1:0]  sharp,
        input logic [BRIGHT_W-1:0] bright
    );
        verdict_t           v;
        int                 n;
        int                 pos_now;
        int                 goal;
        int                 best;
        bit                 flush;
        logic [STAMP_W-1:0] skew;
        logic [TAG_W-1:0]   pick_tag;
        logic [STAMP_W-1:0] pick_stamp;

        v = '0;
        n = (keep_one_in == 0) ? 1 : int'(keep_one_in);

        if (ls != 0 && rs != 0)
        begin
            skew = (ls >= rs) ? ls - rs : rs - ls;
            if (skew > MAX_SKEW_US)
            begin
                v.status = ST_DESYNC;
                return v;
            end
        end

        pos_now = stride_pos;
        stride_pos = (stride_pos + 1 >= n) ? 0 : stride_pos + 1;

        if (!quality_mode)
        begin
            if (n > 1 && pos_now != 0)
                v.status = ST_DECIMATED;
            else if (too_soon(ls))
                v.status = ST_RATE;
            else
            begin
                if (min_gap_us != 0 && ls != 0)
                    last_pick_us = ls;
                v.status = ST_SELECTED;
                v.tag    = tag;
                v.stamp  = ls;
            end
            return v;
        end

        if ((sharp_floor != 0 && sharp < sharp_floor) ||
            (!bright_floor[16] && {1'b0, bright} < bright_floor) ||
            (bright_ceil <= BRIGHT_GATE_OFF && {1'b0, bright} > bright_ceil))
        begin
            v.status = ST_QUALITY;
            return v;
        end

        goal = (window_goal == 0) ? 1 : int'(window_goal);
        if (goal > WINDOW_DEPTH)
            goal = WINDOW_DEPTH;
        if (cand_count >= WINDOW_DEPTH)
            shift_out_oldest();
        cand_tag[cand_count]   = tag;
        cand_stamp[cand_count] = ls;
        cand_score[cand_count] = sharp;
        cand_count++;
        if (cand_count > goal)
            shift_out_oldest();

        flush = (cand_count >= goal);
        if (!flush && age_limit_us != 0 && ls != 0 && cand_stamp[0] != 0 &&
            ls >= cand_stamp[0] && (ls - cand_stamp[0]) >= {24'd0, age_limit_us})
            flush = 1'b1;

        if (!flush)
        begin
            v.status = ST_HELD;
            return v;
        end

        best = 0;
        for (int i = 1; i < cand_count; i++)
            if (cand_score[i] > cand_score[best])
                best = i;
        pick_tag   = cand_tag[best];
        pick_stamp = cand_stamp[best];
        cand_count = 0;
        if (too_soon(pick_stamp))
            v.status = ST_FLUSH_RATE;
        else
        begin
            if (pick_stamp != 0)
                last_pick_us = pick_stamp;
            v.status = ST_SELECTED;
            v.tag    = pick_tag;
            v.stamp  = pick_stamp;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            quality_mode = RST_SELECT_MODE;
            keep_one_in  = RST_DECIMATION;
            min_gap_us   = RST_MIN_INTERVAL;
            sharp_floor  = RST_MIN_SHARP;
            bright_floor = RST_MIN_BRIGHT;
            bright_ceil  = RST_MAX_BRIGHT;
            window_goal  = RST_WINDOW_SIZE;
            age_limit_us = RST_WINDOW_LAT;
            stride_pos   = 0;
            last_pick_us = '0;
            cand_count   = 0;
            verdict_q.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SELECT_MODE:   quality_mode = cfg_data[0];
                    REG_DECIMATION:
                    begin
                        keep_one_in = cfg_data[7:0];
                        stride_pos  = 0;
                    end
                    REG_MIN_INTERVAL:  min_gap_us   = cfg_data[23:0];
                    REG_MIN_SHARPNESS: sharp_floor  = cfg_data;
                    REG_MIN_BRIGHT:    bright_floor = cfg_data[16:0];
                    REG_MAX_BRIGHT:    bright_ceil  = cfg_data[16:0];
                    REG_WINDOW_SIZE:   window_goal  = cfg_data[3:0];
                    REG_WINDOW_LAT:    age_limit_us = cfg_data[23:0];
                    default: ;
                endcase
            end

            // result beat belongs to an earlier input beat, so take it before adding
            if (out_valid && !out_stall)
            begin
                got.status = status;
                got.tag    = selected_tag;
                got.stamp  = selected_stamp_us;
                if (verdict_q.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d tag %h stamp %h",
                           got.status, got.tag, got.stamp);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.tag !== want.tag)
                    begin
                        $error("selected_tag: expected %h, got %h", want.tag, got.tag);
                        mismatches++;
                    end
                    if (got.stamp !== want.stamp)
                    begin
                        $error("selected_stamp_us: expected %h, got %h",
                               want.stamp, got.stamp);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
                verdict_q.insert(verdict_q.size(),
                                 judge_frame(frame_tag, left_stamp_us, right_stamp_us,
                                             sharpness, brightness));

            outstanding = verdict_q.size();
        end
    end

endmodule

FILE: bench/stereo_frame_selector_test.sv
module stereo_frame_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssel_pkg::*;

    localparam int ROUNDS           = 16;
    localparam int FRAMES_PER_ROUND = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [TAG_W-1:0]      frame_tag;
    logic [STAMP_W-1:0]    left_stamp_us;
    logic [STAMP_W-1:0]    right_stamp_us;
    logic [SHARP_W-1:0]    sharpness;
    logic [BRIGHT_W-1:0]   brightness;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [TAG_W-1:0]      selected_tag;
    logic [STAMP_W-1:0]    selected_stamp_us;
    int                    mismatches;
    int                    outstanding;

    // shaping of the current round
    logic [STAMP_W-1:0] now_us;
    int                 span_us;
    logic [31:0]        knob_sharp;
    logic [16:0]        knob_bfloor;
    logic [16:0]        knob_bceil;
    bit                 steady;
    int                 burst_left;

    int stall_pct  = 0;
    int stall_left = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    stereo_frame_selector dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .frame_tag         (frame_tag),
        .left_stamp_us     (left_stamp_us),
        .right_stamp_us    (right_stamp_us),
        .sharpness         (sharpness),
        .brightness        (brightness),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .selected_tag      (selected_tag),
        .selected_stamp_us (selected_stamp_us)
    );

    stereo_frame_selector_check frame_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .frame_tag         (frame_tag),
        .left_stamp_us     (left_stamp_us),
        .right_stamp_us    (right_stamp_us),
        .sharpness         (sharpness),
        .brightness        (brightness),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .selected_tag      (selected_tag),
        .selected_stamp_us (selected_stamp_us),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // receiver: stretches of differing stall density, some with none
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pct  = $urandom_range(0, 3) * 30;
            stall_left = $urandom_range(40, 400);
        end
        else
            stall_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        #4_000_000;
        $display("stereo_frame_selector_test: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
    endtask

    task automatic send_frame(
        input logic [TAG_W-1:0]    tag,
        input logic [STAMP_W-1:0]  ls,
        input logic [STAMP_W-1:0]  rs,
        input logic [SHARP_W-1:0]  sharp,
        input logic [BRIGHT_W-1:0] bright
    );
        frame_tag      = tag;
        left_stamp_us  = ls;
        right_stamp_us = rs;
        sharpness      = sharp;
        brightness     = bright;
        in_valid       = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle(input int cycles);
        if (cycles > 0)
        begin
            in_valid = 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic random_frame();
        logic [STAMP_W-1:0]  ls;
        logic [STAMP_W-1:0]  rs;
        logic [SHARP_W-1:0]  sh;
        logic [BRIGHT_W-1:0] br;
        int                  k;
        int                  lo_b;
        int                  hi_b;

        now_us = now_us + $urandom_range(0, span_us);
        ls = now_us;
        k = $urandom_range(0, 39);
        if (k == 0)
            ls = '0;
        else if (k == 1)
            ls = STAMP_W'({$urandom, $urandom});
        else if (k <= 3)
            ls = now_us - $urandom_range(0, 50000);

        k = $urandom_range(0, 39);
        if (k < 30)
            rs = ls + $urandom_range(0, 4000) - 2000;
        else if (k < 34)
            rs = ls + 2001 + $urandom_range(0, 100000);
        else if (k < 36)
            rs = ls - 2001 - $urandom_range(0, 10);
        else if (k < 38)
            rs = '0;
        else
            rs = STAMP_W'({$urandom, $urandom});

        k = $urandom_range(0, 7);
        if (k < 2)
            sh = $urandom;
        else if (k < 6)
            sh = knob_sharp + $urandom_range(0, 3);
        else if (k == 6)
            sh = knob_sharp - 1;
        else
            sh = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;

        lo_b = knob_bfloor[16] ? 0 : int'(knob_bfloor);
        hi_b = (knob_bceil > 17'd65535) ? 65535 : int'(knob_bceil);
        k = $urandom_range(0, 7);
        case (k)
            2:       br = knob_bfloor[15:0];
            3:       br = knob_bfloor[15:0] - 16'd1;
            4:       br = knob_bceil[15:0];
            5:       br = knob_bceil[15:0] + 16'd1;
            6, 7:    br = BRIGHT_W'((lo_b <= hi_b) ? $urandom_range(lo_b, hi_b) : $urandom);
            default: br = BRIGHT_W'($urandom);
        endcase

        send_frame(TAG_W'($urandom), ls, rs, sh, br);
    endtask

    task automatic random_round(input int which);
        logic [31:0] sel;
        logic [31:0] dec;
        logic [31:0] gap;
        logic [31:0] sf;
        logic [31:0] bf;
        logic [31:0] bc;
        logic [31:0] ws;
        logic [31:0] age;
        int          i;

        drain();
        if (which == 0)
        begin
            sel = 1; dec = 1; gap = 0; sf = 0;
            bf = 32'h1FFFF; bc = 0; ws = 1; age = 0;
        end
        else if (which == 1)
        begin
            sel = 1; dec = 255; gap = 32'hFF_FFFF; sf = 32'hFFFF_FFFF;
            bf = 65535; bc = 65536; ws = 8; age = 32'hFF_FFFF;
        end
        else
        begin
            sel = 32'($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 5))
                0:       dec = 0;
                1, 2:    dec = 1;
                3, 4:    dec = $urandom_range(2, 6);
                default: dec = 255;
            endcase
            case ($urandom_range(0, 4))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 20000);
                2:       gap = $urandom_range(20000, 200000);
                3:       gap = 32'hFF_FFFF;
                default: gap = 1;
            endcase
            case ($urandom_range(0, 3))
                0:       sf = 0;
                1:       sf = $urandom;
                2:       sf = $urandom_range(0, 1000);
                default: sf = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 4))
                0:       bf = 32'h1FFFF;
                1:       bf = 32'h10000;
                2:       bf = 0;
                3:       bf = $urandom_range(0, 40000);
                default: bf = 65535;
            endcase
            case ($urandom_range(0, 5))
                0:       bc = 65536;
                1:       bc = 65281;
                2:       bc = 65280;
                3:       bc = $urandom_range(20000, 65535);
                4:       bc = 0;
                default: bc = $urandom_range(65536, 131071);
            endcase
            case ($urandom_range(0, 4))
                0:       ws = 0;
                1, 2:    ws = $urandom_range(1, 8);
                3:       ws = $urandom_range(9, 15);
                default: ws = 8;
            endcase
            case ($urandom_range(0, 3))
                0:       age = 0;
                1:       age = $urandom_range(1000, 100000);
                2:       age = $urandom_range(1, 5000);
                default: age = 32'hFF_FFFF;
            endcase
        end

        write_reg(REG_SELECT_MODE, sel);
        write_reg(REG_DECIMATION, dec);
        write_reg(REG_MIN_INTERVAL, gap);
        write_reg(REG_MIN_SHARPNESS, sf);
        write_reg(REG_MIN_BRIGHT, bf);
        write_reg(REG_MAX_BRIGHT, bc);
        write_reg(REG_WINDOW_SIZE, ws);
        write_reg(REG_WINDOW_LAT, age);
        cfg_we = 1'b0;

        knob_sharp  = sf;
        knob_bfloor = bf[16:0];
        knob_bceil  = bc[16:0];
        case ($urandom_range(0, 3))
            0:       span_us = 100;
            1:       span_us = 3000;
            2:       span_us = 30000;
            default: span_us = 300000;
        endcase
        case ($urandom_range(0, 5))
            0, 1:    now_us = STAMP_W'($urandom_range(1, 1000000));
            2:       now_us = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 500000);
            default: now_us = STAMP_W'({$urandom, $urandom});
        endcase
        steady = ($urandom_range(0, 3) == 0);
        burst_left = 0;

        for (i = 0; i < FRAMES_PER_ROUND; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (!steady)
                    idle($urandom_range(0, 9));
            end
            random_frame();
            burst_left--;
            if (i % 32 == 31 && $urandom_range(0, 3) == 0)
                drain();
        end
    endtask

    initial
    begin
        int r;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        frame_tag      = '0;
        left_stamp_us  = '0;
        right_stamp_us = '0;
        sharpness      = '0;
        brightness     = '0;
        now_us         = '0;
        span_us        = 0;
        knob_sharp     = '0;
        knob_bfloor    = '0;
        knob_bceil     = '0;
        steady         = 1'b0;
        burst_left     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // stride defaults: extremes, skew edges, zero stamps
        send_frame(16'h0000, 48'd1000, 48'd1000, 32'd0, 16'h0000);
        send_frame(16'hFFFF, '1, '1, '1, '1);
        send_frame(16'h1234, 48'd5000, 48'd7001, 32'd10, 16'd10);
        send_frame(16'h2345, 48'd7000, 48'd5000, 32'd10, 16'd10);
        send_frame(16'h3456, 48'd0, 48'd123456789, 32'd10, 16'd10);

        // one in three, with a rate limit
        drain();
        write_reg(REG_DECIMATION, 32'd3);
        write_reg(REG_MIN_INTERVAL, 32'd10000);
        cfg_we = 1'b0;
        send_frame(16'h0101, 48'd100000, 48'd100000, 32'd1, 16'd1);
        send_frame(16'h0102, 48'd101000, 48'd101000, 32'd1, 16'd1);
        send_frame(16'h0103, 48'd102000, 48'd102000, 32'd1, 16'd1);
        send_frame(16'h0104, 48'd105000, 48'd105000, 32'd1, 16'd1);
        send_frame(16'h0105, 48'd200000, 48'd300000, 32'd1, 16'd1);
        send_frame(16'h0106, 48'd106000, 48'd106000, 32'd1, 16'd1);
        send_frame(16'h0107, 48'd107000, 48'd107000, 32'd1, 16'd1);
        send_frame(16'h0108, 48'd120000, 48'd120000, 32'd1, 16'd1);

        // decimation of zero acts as one; a stamp behind the last one passes
        drain();
        write_reg(REG_DECIMATION, 32'd0);
        cfg_we = 1'b0;
        send_frame(16'h0201, 48'd121000, 48'd121000, 32'd1, 16'd1);
        send_frame(16'h0202, 48'd50000, 48'd50000, 32'd1, 16'd1);

        // quality gates, window flush on size, tie on score, flush rate limit
        drain();
        write_reg(REG_SELECT_MODE, 32'd1);
        write_reg(REG_DECIMATION, 32'd1);
        write_reg(REG_MIN_SHARPNESS, 32'd1000);
        write_reg(REG_MIN_BRIGHT, 32'd256);
        write_reg(REG_MAX_BRIGHT, 32'd60000);
        write_reg(REG_WINDOW_SIZE, 32'd3);
        write_reg(REG_WINDOW_LAT, 32'd0);
        cfg_we = 1'b0;
        send_frame(16'h0301, 48'd190000, 48'd190000, 32'd999, 16'd1000);
        send_frame(16'h0302, 48'd191000, 48'd191000, 32'd2000, 16'd255);
        send_frame(16'h0303, 48'd192000, 48'd192000, 32'd2000, 16'd60001);
        send_frame(16'h0304, 48'd200000, 48'd200000, 32'd5000, 16'd256);
        send_frame(16'h0305, 48'd201000, 48'd201000, 32'd7000, 16'd60000);
        send_frame(16'h0306, 48'd202000, 48'd202000, 32'd7000, 16'd30000);
        send_frame(16'h0307, 48'd203000, 48'd203000, 32'd3000, 16'd30000);
        send_frame(16'h0308, 48'd204000, 48'd204000, 32'd4000, 16'd30000);
        send_frame(16'h0309, 48'd205000, 48'd205000, 32'd9000, 16'd30000);

        // oversized window, flush on age
        drain();
        write_reg(REG_WINDOW_SIZE, 32'd9);
        write_reg(REG_WINDOW_LAT, 32'd5000);
        cfg_we = 1'b0;
        send_frame(16'h0401, 48'd300000, 48'd300000, 32'd6000, 16'd30000);
        send_frame(16'h0402, 48'd306000, 48'd306000, 32'd5000, 16'd30000);

        // window size of zero acts as one
        drain();
        write_reg(REG_WINDOW_SIZE, 32'd0);
        cfg_we = 1'b0;
        send_frame(16'h0501, 48'd306500, 48'd306500, 32'd5000, 16'd30000);

        for (r = 0; r < ROUNDS; r++)
            random_round(r);

        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("stereo_frame_selector_test: done, clean");
        else
            $display("stereo_frame_selector_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/ssel_pkg.sv
hdl/ssel_ctrl.sv
hdl/ssel_dp.sv
hdl/stereo_frame_selector.sv
hdl/ssel_chk.sv
bench/stereo_frame_selector_check.sv
bench/stereo_frame_selector_test.sv
